@@ design/biquad_lowpass_sample_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Biquad low-pass sample engine: assertion macros
// Shared property shorthands for the engine's RTL, clocked on clk, off in rst.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_LOWPASS_SAMPLE_ENGINE_UNIT_DEFINES_SVH
`define BIQUAD_LOWPASS_SAMPLE_ENGINE_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define BLPSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the following cycle
`define BLPSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/blpse_pkg.sv @@
// ----------------------------------------------------------------------------
// blpse_pkg
// Widths, register codes, sequencer steps and rounding helpers of the engine.
// ----------------------------------------------------------------------------
package blpse_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 4;
  localparam int Y_BITS         = 32;
  localparam int GAIN_BITS      = 16;
  localparam int VOL_BITS       = 8;
  localparam int IN_GAIN_FRAC   = 14;
  localparam int MIX_FRAC       = 20;

  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 32;

  // shared multiplier: covers y*volume product as the A operand of the mix step
  localparam int MUL_A_W        = Y_BITS + VOL_BITS + 2;
  localparam int MUL_B_W        = COEF_BITS + 1;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;
  localparam int ACC_W          = Y_BITS + COEF_BITS + 4;

  localparam int NUM_TAPS       = 5;
  localparam int TAP_W          = $clog2(NUM_TAPS);

  localparam logic [GAIN_BITS-1:0] IN_GAIN_RESET  = GAIN_BITS'(16384);
  localparam logic [GAIN_BITS-1:0] MIX_GAIN_RESET = GAIN_BITS'(10486);
  localparam logic [VOL_BITS-1:0]  VOLUME_RESET   = VOL_BITS'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0    = CFG_IDX_W'(0),
    REG_COEF_B1    = CFG_IDX_W'(1),
    REG_COEF_B2    = CFG_IDX_W'(2),
    REG_COEF_FB1   = CFG_IDX_W'(3),
    REG_COEF_FB2   = CFG_IDX_W'(4),
    REG_IN_GAIN    = CFG_IDX_W'(5),
    REG_MIX_GAIN   = CFG_IDX_W'(6),
    REG_OUT_VOLUME = CFG_IDX_W'(7)
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_b0;
    logic signed [COEF_BITS-1:0] coef_b1;
    logic signed [COEF_BITS-1:0] coef_b2;
    logic signed [COEF_BITS-1:0] coef_fb1;
    logic signed [COEF_BITS-1:0] coef_fb2;
    logic [GAIN_BITS-1:0]        in_gain;
    logic [GAIN_BITS-1:0]        mix_gain;
    logic [VOL_BITS-1:0]         out_volume;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_XSAT,
    ST_MAC,
    ST_ACCL,
    ST_YSAT,
    ST_VOL,
    ST_MIX,
    ST_OSAT
  } state_t;

  typedef struct packed {
    state_t           step;
    logic [TAP_W-1:0] tap;
    logic             load;
    logic             commit;
  } ctl_t;

  // round half up by 2^sh, then clamp to a signed field of the given width
  function automatic logic signed [Y_BITS-1:0] rnd_sat(
    input logic signed [PROD_W-1:0] v,
    input int                       sh,
    input int                       bits
  );
    logic signed [PROD_W:0] t;
    logic signed [PROD_W:0] half;
    logic signed [PROD_W:0] hi;
    logic signed [PROD_W:0] lo;
    half = (PROD_W + 1)'(1) <<< (sh - 1);
    hi   = ((PROD_W + 1)'(1) <<< (bits - 1)) - (PROD_W + 1)'(1);
    lo   = -hi - (PROD_W + 1)'(1);
    t    = ((PROD_W + 1)'(v) + half) >>> sh;
    if (t > hi) begin
      t = hi;
    end else if (t < lo) begin
      t = lo;
    end
    return Y_BITS'(t);
  endfunction

endpackage

@@ design/blpse_ctrl.sv @@
// ----------------------------------------------------------------------------
// blpse_ctrl
// Step sequencer for the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module blpse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_free,
  output logic              busy,
  output blpse_pkg::ctl_t   ctl
);
  import blpse_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [TAP_W-1:0] tap;
  logic [TAP_W-1:0] tap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_GAIN;
      end
      ST_GAIN: state_next = ST_XSAT;
      ST_XSAT: begin
        state_next = ST_MAC;
        tap_next   = '0;
      end
      ST_MAC: begin
        if (tap == TAP_W'(NUM_TAPS - 1)) begin
          state_next = ST_ACCL;
        end else begin
          tap_next = tap + TAP_W'(1);
        end
      end
      ST_ACCL: state_next = ST_YSAT;
      ST_YSAT: state_next = ST_VOL;
      ST_VOL:  state_next = ST_MIX;
      ST_MIX:  state_next = ST_OSAT;
      ST_OSAT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    ctl.step   = state;
    ctl.tap    = tap;
    ctl.load   = (state == ST_IDLE) && start;
    ctl.commit = (state == ST_OSAT) && out_free;
  end

endmodule

@@ design/blpse_datapath.sv @@
// ----------------------------------------------------------------------------
// blpse_datapath
// Shared multiplier, accumulator, round/saturate and filter history.
// ----------------------------------------------------------------------------
module blpse_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  blpse_pkg::ctl_t                          ctl,
  input  blpse_pkg::cfg_t                          cfg,
  input  logic signed [blpse_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic signed [blpse_pkg::SAMPLE_BITS-1:0] result
);
  import blpse_pkg::*;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] x_prev1;
  logic signed [SAMPLE_BITS-1:0] x_prev2;
  logic signed [Y_BITS-1:0]      y;
  logic signed [Y_BITS-1:0]      y_prev1;
  logic signed [Y_BITS-1:0]      y_prev2;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;

  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic                          mul_en;
  logic signed [Y_BITS-1:0]      x_round;
  logic signed [Y_BITS-1:0]      y_round;
  logic signed [Y_BITS-1:0]      out_round;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (ctl.step)
      ST_GAIN: begin
        mul_a = MUL_A_W'(sample);
        mul_b = $signed(MUL_B_W'(cfg.in_gain));
      end
      ST_MAC: begin
        unique case (ctl.tap)
          TAP_W'(0): begin
            mul_a = MUL_A_W'(x);
            mul_b = MUL_B_W'(cfg.coef_b0);
          end
          TAP_W'(1): begin
            mul_a = MUL_A_W'(x_prev1);
            mul_b = MUL_B_W'(cfg.coef_b1);
          end
          TAP_W'(2): begin
            mul_a = MUL_A_W'(x_prev2);
            mul_b = MUL_B_W'(cfg.coef_b2);
          end
          TAP_W'(3): begin
            mul_a = MUL_A_W'(y_prev1);
            mul_b = MUL_B_W'(cfg.coef_fb1);
          end
          default: begin
            mul_a = MUL_A_W'(y_prev2);
            mul_b = MUL_B_W'(cfg.coef_fb2);
          end
        endcase
      end
      ST_VOL: begin
        mul_a = MUL_A_W'(y);
        mul_b = $signed(MUL_B_W'(cfg.out_volume));
      end
      ST_MIX: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = $signed(MUL_B_W'(cfg.mix_gain));
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign x_round   = rnd_sat(prod, IN_GAIN_FRAC, SAMPLE_BITS);
  assign y_round   = rnd_sat(PROD_W'(acc), COEF_FRAC_BITS, Y_BITS);
  assign out_round = rnd_sat(prod, MIX_FRAC, SAMPLE_BITS);
  assign result    = out_round[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) sample <= in_sample;
    if (mul_en) prod <= mul_a * mul_b;
    if (ctl.step == ST_XSAT) begin
      x   <= x_round[SAMPLE_BITS-1:0];
      acc <= '0;
    end else if ((ctl.step == ST_MAC && ctl.tap != '0) || ctl.step == ST_ACCL) begin
      acc <= acc + $signed(prod[ACC_W-1:0]);
    end
    if (ctl.step == ST_YSAT) y <= y_round;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_prev1 <= '0;
      x_prev2 <= '0;
      y_prev1 <= '0;
      y_prev2 <= '0;
    end else if (ctl.commit) begin
      x_prev2 <= x_prev1;
      x_prev1 <= x;
      y_prev2 <= y_prev1;
      y_prev1 <= y;
    end
  end

endmodule

@@ design/biquad_lowpass_sample_engine_unit.sv @@
// ----------------------------------------------------------------------------
// biquad_lowpass_sample_engine_unit
// Direct form I biquad with input gain and mix/volume output scaling.
// ----------------------------------------------------------------------------
// One word in, one word out. A sample is taken when in_valid is high and
// in_stall is low; in_stall then stays high while a single shared 42x21
// multiplier runs eight products in turn (input gain, five filter taps,
// volume, mix) and until the result is committed, so a new sample is taken
// only once the previous result is registered. The result sits in an
// output register until taken; if it is still held when the next one
// finishes, the sequencer waits in its last step. Coefficients are Q4.16,
// in_gain is scaled by 2^-14 and volume times mix_gain by 2^-20; the
// filter output is saturated to 32 bits, the result to 24 bits.
`include "biquad_lowpass_sample_engine_unit_defines.svh"

module biquad_lowpass_sample_engine_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [blpse_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [blpse_pkg::SAMPLE_BITS-1:0] out_sample,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [blpse_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [blpse_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import blpse_pkg::*;

  cfg_t                          cfg;
  ctl_t                          ctl;
  logic                          busy;
  logic                          start;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] result;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_b0    <= '0;
      cfg.coef_b1    <= '0;
      cfg.coef_b2    <= '0;
      cfg.coef_fb1   <= '0;
      cfg.coef_fb2   <= '0;
      cfg.in_gain    <= IN_GAIN_RESET;
      cfg.mix_gain   <= MIX_GAIN_RESET;
      cfg.out_volume <= VOLUME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_B0:    cfg.coef_b0    <= $signed(cfg_data[COEF_BITS-1:0]);
        REG_COEF_B1:    cfg.coef_b1    <= $signed(cfg_data[COEF_BITS-1:0]);
        REG_COEF_B2:    cfg.coef_b2    <= $signed(cfg_data[COEF_BITS-1:0]);
        REG_COEF_FB1:   cfg.coef_fb1   <= $signed(cfg_data[COEF_BITS-1:0]);
        REG_COEF_FB2:   cfg.coef_fb2   <= $signed(cfg_data[COEF_BITS-1:0]);
        REG_IN_GAIN:    cfg.in_gain    <= cfg_data[GAIN_BITS-1:0];
        REG_MIX_GAIN:   cfg.mix_gain   <= cfg_data[GAIN_BITS-1:0];
        REG_OUT_VOLUME: cfg.out_volume <= cfg_data[VOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  blpse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  blpse_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .in_sample (in_sample),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) out_sample <= result;
  end

  `BLPSE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
  `BLPSE_ASSERT_NOW(a_commit_into_free_slot, ctl.commit, !out_valid || !out_stall, "overwrite")
  `BLPSE_ASSERT_NOW(a_out_from_commit, $rose(out_valid), $past(ctl.commit), "word without commit")
  `BLPSE_ASSERT_NOW(a_tap_in_range, ctl.step == ST_MAC, ctl.tap <= TAP_W'(NUM_TAPS - 1), "bad tap")

endmodule
